/* rtl/sensor_frame_checksum_parser_macros.svh */
// Assertion macros used by the sensor frame parser output buffer.
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_MACROS_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SFCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SFCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sfcp_pkg.sv */
// Types and constants shared by the sensor frame parser modules.
package sfcp_pkg;

    localparam int unsigned STORE_DEPTH = 10;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [7:0] HDR_BYTE   = 8'h5A;
    localparam logic [7:0] TYPE_LIGHT = 8'h15;
    localparam logic [7:0] TYPE_ENV   = 8'h45;
    localparam logic [7:0] LEN_LIGHT  = 8'd4;
    localparam logic [7:0] LEN_ENV    = 8'd10;

    localparam logic [1:0] STATUS_LIGHT   = 2'd0;
    localparam logic [1:0] STATUS_ENV     = 2'd1;
    localparam logic [1:0] STATUS_SUM_ERR = 2'd2;

    // Packed output word width: lux, temp, press, hum, altitude.
    localparam int unsigned OUT_DATA_W = 112;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lux_raw;
        logic [15:0] temp_raw;
        logic [31:0] press_raw;
        logic [15:0] hum_raw;
        logic [15:0] altitude_m;
    } result_t;

endpackage

/* rtl/sfcp_parser.sv */
// Frame parser: header hunt, running checksum, data capture and result decode.
module sfcp_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    output logic                   res_valid,
    output sfcp_pkg::result_t      res
);
    import sfcp_pkg::*;

    phase_t     phase_reg,  phase_next;
    logic [7:0] sum_reg,    sum_next;
    logic [7:0] type_reg,   type_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] index_reg,  index_next;
    logic [7:0] index_inc;
    logic [7:0] payload_reg [STORE_DEPTH];
    logic       store_en;

    assign index_inc = index_reg + 8'd1;
    assign store_en  = byte_valid && (phase_reg == PH_DATA)
                       && (index_reg < 8'(STORE_DEPTH));

    // Next state and result decode for the word presented this cycle.
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        index_next = index_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (byte_data == HDR_BYTE)
                    begin
                        sum_next   = sum_reg + byte_data;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = byte_data;
                    sum_next   = sum_reg + byte_data;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = byte_data;
                    index_next = 8'd0;
                    sum_next   = sum_reg + byte_data;
                    phase_next = (byte_data == 8'd0) ? PH_SUM : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next   = sum_reg + byte_data;
                    index_next = index_inc;
                    if (index_inc >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    phase_next = PH_HUNT0;
                    if (byte_data != sum_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_SUM_ERR;
                    end
                    else if (type_reg == TYPE_LIGHT && len_reg == LEN_LIGHT)
                    begin
                        res_valid   = 1'b1;
                        res.status  = STATUS_LIGHT;
                        res.lux_raw = {payload_reg[0], payload_reg[1],
                                       payload_reg[2], payload_reg[3]};
                    end
                    else if (type_reg == TYPE_ENV && len_reg == LEN_ENV)
                    begin
                        res_valid      = 1'b1;
                        res.status     = STATUS_ENV;
                        res.temp_raw   = {payload_reg[0], payload_reg[1]};
                        res.press_raw  = {payload_reg[2], payload_reg[3],
                                          payload_reg[4], payload_reg[5]};
                        res.hum_raw    = {payload_reg[6], payload_reg[7]};
                        res.altitude_m = {payload_reg[8], payload_reg[9]};
                    end
                end
                default:
                begin
                    // Hunting the first header byte; unused codes land here too.
                    if (byte_data == HDR_BYTE)
                    begin
                        sum_next   = byte_data;
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT0;
                    end
                end
            endcase
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT0;
            sum_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            index_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            index_reg <= index_next;
        end
    end

    // Capture of the first data bytes of a frame.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[index_reg[IDX_W-1:0]] <= byte_data;
        end
    end

endmodule

/* rtl/sfcp_out_buf.sv */
// Result register with a skid stage between the parser and the output stream.
`include "sensor_frame_checksum_parser_macros.svh"

module sfcp_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  sfcp_pkg::result_t      in_res,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sfcp_pkg::result_t      out_res
);
    import sfcp_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg,    out_res_next;
    result_t skid_res_reg,   skid_res_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // The output register refills from the skid stage first, else from the parser.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    `SFCP_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid stage holds a word while the output register is empty")
    `SFCP_ASSERT_NEXT(a_stall_fills_skid,
        out_valid_reg && !out_ready && !skid_valid_reg && in_valid, skid_valid_reg,
        "stalled result was dropped instead of parked in the skid stage")
    `SFCP_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ready,
        out_valid_reg && !skid_valid_reg,
        "skid stage did not move into the output register")
    `SFCP_ASSERT_NEXT(a_idle_empties,
        out_valid_reg && out_ready && !skid_valid_reg && !in_valid, !out_valid_reg,
        "output stayed valid after its word was taken")

endmodule

/* rtl/sensor_frame_checksum_parser.sv */
// Top level of the framed sensor report parser.
//
//   channel   dir  tdata                              tuser
//   s_axis    in   rx_byte[7:0]                       -
//   m_axis    out  lux,temp,press,hum,alt (112 bits)  status[1:0]
//
// One received word is taken per cycle while s_axis_tready is high; the
// header, type, length and data bytes update the phase and running sum in that
// same cycle, the checksum byte the phase alone. Results reach m_axis registered.
// A stalled result waits in the output register; a second one parks in the
// skid stage, and s_axis_tready drops only while that stage is occupied.
// Reset (rst_n low) returns the parser to the header hunt with an empty output.
module sensor_frame_checksum_parser
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sfcp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [31:0] lux_raw,
                                                               // [47:32] temp_raw,
                                                               // [79:48] press_raw,
                                                               // [95:80] hum_raw,
                                                               // [111:96] altitude_m
    output logic [1:0]                         m_axis_tuser    // [1:0] status
);
    import sfcp_pkg::*;

    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign byte_accept = s_axis_tvalid && s_axis_tready;

    sfcp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .byte_data  (s_axis_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfcp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tdata = {out_res.altitude_m, out_res.hum_raw, out_res.press_raw,
                           out_res.temp_raw, out_res.lux_raw};
    assign m_axis_tuser = out_res.status;

endmodule

/* sim/sensor_frame_checksum_parser_tb.sv */
// Self-checking testbench for the framed sensor report parser.
`timescale 1ns / 1ps

module sensor_frame_checksum_parser_tb;

    import sfcp_pkg::*;

    localparam int RANDOM_BYTES   = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTED   = 10;

    // Kinds of frame that the random part builds.
    typedef enum {
        FR_LIGHT,
        FR_ENV,
        FR_BAD_SUM,
        FR_OTHER,
        FR_CROSSED,
        FR_EMPTY_BAD,
        FR_BROKEN_HDR,
        FR_NOISE
    } frame_kind_t;

    // One row of the directed table: a byte and, where it is obvious, the report it closes.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t BAD_SUM_REPORT =
        '{STATUS_SUM_ERR, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0};
    localparam result_t FULL_LUX_REPORT =
        '{STATUS_LIGHT, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0, 16'h0};
    localparam result_t ENV_REPORT =
        '{STATUS_ENV, 32'h0, 16'h09C4, 32'h0001_8A88, 16'h1388, 16'h0064};

    localparam dir_row_t DIR_TABLE [36] = '{
        // A broken header drops back to the hunt.
        '{8'h5A, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        // Zero length: the byte after the length is the checksum, here a wrong one.
        '{8'h5A, 1'b0, NO_RESULT}, '{8'h5A, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, BAD_SUM_REPORT},
        // Light frame with every data bit set.
        '{8'h5A, 1'b0, NO_RESULT}, '{8'h5A, 1'b0, NO_RESULT},
        '{8'h15, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hC9, 1'b1, FULL_LUX_REPORT},
        // Unknown type with a good checksum gives nothing.
        '{8'h5A, 1'b0, NO_RESULT}, '{8'h5A, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hB3, 1'b0, NO_RESULT},
        // Environment frame with distinct values in every field.
        '{8'h5A, 1'b0, NO_RESULT}, '{8'h5A, 1'b0, NO_RESULT},
        '{8'h45, 1'b0, NO_RESULT}, '{8'h0A, 1'b0, NO_RESULT},
        '{8'h09, 1'b0, NO_RESULT}, '{8'hC4, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
        '{8'h8A, 1'b0, NO_RESULT}, '{8'h88, 1'b0, NO_RESULT},
        '{8'h13, 1'b0, NO_RESULT}, '{8'h88, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h64, 1'b0, NO_RESULT},
        '{8'hE2, 1'b1, ENV_REPORT}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;     // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;     // [31:0] lux_raw, [47:32] temp_raw,
                                              // [79:48] press_raw, [95:80] hum_raw,
                                              // [111:96] altitude_m
    logic [1:0]             m_axis_tuser;     // [1:0] status

    // Parser state as the testbench tracks it.
    phase_t      frame_phase = PH_HUNT0;
    logic [7:0]  frame_sum   = '0;
    logic [7:0]  frame_type  = '0;
    logic [7:0]  frame_len   = '0;
    logic [7:0]  data_count  = '0;
    logic [7:0]  data_store [STORE_DEPTH];

    result_t     expected_reports [$];
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int          stall_cycles = 0;
    bit          hold_req    = 1'b0;
    bit          holding     = 1'b0;
    bit          finished    = 1'b0;

    sensor_frame_checksum_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the tracked parser by one byte; a closed frame may yield a report.
    function automatic void parse_rx_byte(input logic [7:0] rx, output bit got,
                                          output result_t rep);
        got = 1'b0;
        rep = '0;
        case (frame_phase)
            PH_HUNT1:
            begin
                if (rx == HDR_BYTE)
                begin
                    frame_sum   = frame_sum + rx;
                    frame_phase = PH_TYPE;
                end
                else
                    frame_phase = PH_HUNT0;
            end
            PH_TYPE:
            begin
                frame_type  = rx;
                frame_sum   = frame_sum + rx;
                frame_phase = PH_LEN;
            end
            PH_LEN:
            begin
                frame_len   = rx;
                data_count  = '0;
                frame_sum   = frame_sum + rx;
                frame_phase = (rx == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                // Bytes past the store depth still count toward the sum.
                if (data_count < 8'(STORE_DEPTH))
                    data_store[data_count[IDX_W-1:0]] = rx;
                frame_sum  = frame_sum + rx;
                data_count = data_count + 8'd1;
                if (data_count >= frame_len)
                    frame_phase = PH_SUM;
            end
            PH_SUM:
            begin
                frame_phase = PH_HUNT0;
                if (rx != frame_sum)
                begin
                    got        = 1'b1;
                    rep.status = STATUS_SUM_ERR;
                end
                else if (frame_type == TYPE_LIGHT && frame_len == LEN_LIGHT)
                begin
                    got         = 1'b1;
                    rep.status  = STATUS_LIGHT;
                    rep.lux_raw = {data_store[0], data_store[1], data_store[2], data_store[3]};
                end
                else if (frame_type == TYPE_ENV && frame_len == LEN_ENV)
                begin
                    got            = 1'b1;
                    rep.status     = STATUS_ENV;
                    rep.temp_raw   = {data_store[0], data_store[1]};
                    rep.press_raw  = {data_store[2], data_store[3],
                                      data_store[4], data_store[5]};
                    rep.hum_raw    = {data_store[6], data_store[7]};
                    rep.altitude_m = {data_store[8], data_store[9]};
                end
            end
            default:
            begin
                if (rx == HDR_BYTE)
                begin
                    frame_sum   = rx;
                    frame_phase = PH_HUNT1;
                end
                else
                    frame_phase = PH_HUNT0;
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one word and wait for it to be taken; queue the report it closes.
    task automatic send_byte(input logic [7:0] rx, input logic typed, input result_t want);
        int      gap;
        bit      got;
        result_t rep;
        if (burst_left > 0)
        begin
            gap        = 0;
            burst_left = burst_left - 1;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0)
                burst_left = $urandom_range(20, 80);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_rx_byte(rx, got, rep);
        if (typed)
            expected_reports.push_back(want);
        else if (got)
            expected_reports.push_back(rep);
        bytes_sent = bytes_sent + 1;
    endtask

    // Build one frame (or some line noise) with random content and send it.
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] frame_bytes [$];
        logic [7:0] ftype;
        logic [7:0] flen;
        logic [7:0] csum;
        logic [7:0] flip;
        logic [7:0] b;
        int         n;
        case (kind)
            FR_NOISE:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    b = 8'($urandom_range(0, 255));
                    frame_bytes.push_back(b);
                end
            end
            FR_BROKEN_HDR:
            begin
                flip = 8'($urandom_range(1, 255));
                frame_bytes.push_back(HDR_BYTE);
                frame_bytes.push_back(HDR_BYTE ^ flip);
            end
            default:
            begin
                case (kind)
                    FR_LIGHT:
                    begin
                        ftype = TYPE_LIGHT;
                        flen  = LEN_LIGHT;
                    end
                    FR_ENV:
                    begin
                        ftype = TYPE_ENV;
                        flen  = LEN_ENV;
                    end
                    FR_BAD_SUM:
                    begin
                        ftype = $urandom_range(0, 1) ? TYPE_LIGHT : TYPE_ENV;
                        flen  = (ftype == TYPE_LIGHT) ? LEN_LIGHT : LEN_ENV;
                    end
                    FR_CROSSED:
                    begin
                        ftype = $urandom_range(0, 1) ? TYPE_LIGHT : TYPE_ENV;
                        flen  = (ftype == TYPE_LIGHT) ? LEN_ENV : LEN_LIGHT;
                    end
                    FR_EMPTY_BAD:
                    begin
                        ftype = 8'($urandom_range(0, 255));
                        flen  = 8'd0;
                    end
                    default:
                    begin
                        ftype = 8'($urandom_range(0, 255));
                        flen  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(100, 255))
                                                            : 8'($urandom_range(0, 20));
                    end
                endcase
                frame_bytes.push_back(HDR_BYTE);
                frame_bytes.push_back(HDR_BYTE);
                frame_bytes.push_back(ftype);
                frame_bytes.push_back(flen);
                csum = HDR_BYTE + HDR_BYTE + ftype + flen;
                repeat (flen)
                begin
                    n = $urandom_range(0, 7);
                    b = (n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    frame_bytes.push_back(b);
                    csum = csum + b;
                end
                if (kind == FR_BAD_SUM || kind == FR_EMPTY_BAD)
                begin
                    flip = 8'($urandom_range(1, 255));
                    csum = csum ^ flip;
                end
                frame_bytes.push_back(csum);
            end
        endcase
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b0, NO_RESULT);
    endtask

    // Stop offering words until every queued report has come out, then let the block settle.
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTED)
        begin
            $display("%0t %s: exp st=%0d lux=%h t=%h p=%h h=%h a=%h",
                     $realtime, what,
                     want.status, want.lux_raw, want.temp_raw, want.press_raw,
                     want.hum_raw, want.altitude_m);
            $display("%0t %s: got st=%0d lux=%h t=%h p=%h h=%h a=%h",
                     $realtime, what,
                     got.status, got.lux_raw, got.temp_raw, got.press_raw,
                     got.hum_raw, got.altitude_m);
        end
    endtask

    // Stimulus: reset, the directed table, then random frames with one hold-off and one drain.
    initial
    begin : stimulus
        int          roll;
        frame_kind_t kind;
        bit          held;
        bit          drained;
        held          = 1'b0;
        drained       = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[i])
            send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        wait_for_reports();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (!held && bytes_sent >= 300)
            begin
                // Receiver holds off while short bad frames keep coming, so the output backs up.
                held          = 1'b1;
                s_axis_tvalid <= 1'b0;
                hold_req      = 1'b1;
                while (!holding)
                    @(posedge clk);
                repeat (12) send_frame(FR_EMPTY_BAD);
            end
            else if (!drained && bytes_sent >= 650)
            begin
                drained = 1'b1;
                wait_for_reports();
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 28)
                    kind = FR_LIGHT;
                else if (roll < 56)
                    kind = FR_ENV;
                else if (roll < 66)
                    kind = FR_BAD_SUM;
                else if (roll < 78)
                    kind = FR_OTHER;
                else if (roll < 84)
                    kind = FR_CROSSED;
                else if (roll < 90)
                    kind = FR_BROKEN_HDR;
                else
                    kind = FR_NOISE;
                send_frame(kind);
            end
        end
        wait_for_reports();

        finished   = 1'b1;
        mismatches = mismatches + expected_reports.size();
        if (mismatches == 0)
            $display("** sensor_frame_checksum_parser: PASSED **");
        else
            $display("** sensor_frame_checksum_parser: FAILED **");
        $finish;
    end

    // Receiver: runs of ready with random gaps, and one long hold-off on request.
    initial
    begin : sink
        int run;
        int gap;
        m_axis_tready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req      = 1'b0;
                holding       = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Compare every word taken on the output with the oldest queued report.
    always @(posedge clk)
    begin : check_reports
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status     = m_axis_tuser;
            got.lux_raw    = m_axis_tdata[31:0];
            got.temp_raw   = m_axis_tdata[47:32];
            got.press_raw  = m_axis_tdata[79:48];
            got.hum_raw    = m_axis_tdata[95:80];
            got.altitude_m = m_axis_tdata[111:96];
            if (expected_reports.size() == 0)
                log_mismatch("unexpected report", NO_RESULT, got);
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                    log_mismatch("report mismatch", want, got);
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n && !finished)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** sensor_frame_checksum_parser: FAILED **");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
